/* rtl/dpses_pkg.sv */
package dpses_pkg;

   typedef enum logic [1:0] {
      OP_COMMAND = 2'd0,
      OP_STATUS  = 2'd1,
      OP_ACK     = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CMD_ENABLE          = 3'd0,
      CMD_FAULT_RESET     = 3'd1,
      CMD_DISABLE_VOLTAGE = 3'd2,
      CMD_SHUTDOWN        = 3'd3,
      CMD_QUICK_STOP      = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_NOTREADY = 4'd0,
      ST_SOD      = 4'd1,
      ST_RTSO     = 4'd2,
      ST_SO       = 4'd3,
      ST_OE       = 4'd4,
      ST_QSA      = 4'd5,
      ST_FRA      = 4'd6,
      ST_FAULT    = 4'd7,
      ST_UNKNOWN  = 4'd8
   } drive_state_type;

   typedef enum logic [4:0] {
      S_IDLE       = 5'd0,
      S_SETTLE     = 5'd1,
      S_W_FAULT    = 5'd2,
      S_RST_ACK0   = 5'd3,
      S_RST_DLY1   = 5'd4,
      S_RST_ACK1   = 5'd5,
      S_RST_DLY2   = 5'd6,
      S_RST_ACK2   = 5'd7,
      S_W_SOD_RST  = 5'd8,
      S_W_SOD_NR   = 5'd9,
      S_ACK_SHUT   = 5'd10,
      S_W_RTSO     = 5'd11,
      S_ACK_SWON   = 5'd12,
      S_W_SO       = 5'd13,
      S_ACK_EN     = 5'd14,
      S_W_OE       = 5'd15,
      S_ACK_SINGLE = 5'd16,
      S_W_SINGLE   = 5'd17
   } step_type;

   localparam logic [1:0] REG_LONG_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_SHORT_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_SETTLE        = 2'd2;

   localparam logic [15:0] CW_ZERO        = 16'h0000;
   localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
   localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
   localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
   localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
   localparam logic [15:0] CW_QUICK_STOP  = 16'h0002;

   localparam logic [1:0] FIN_OK         = 2'd0;
   localparam logic [1:0] FIN_WRITE_FAIL = 2'd1;
   localparam logic [1:0] FIN_TIMEOUT    = 2'd2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] status;
      step_type    step;
      logic [15:0] elapsed;
      logic [6:0]  node;
      logic [2:0]  cmd;
   } state_type;

   typedef struct packed {
      logic [15:0] long_timeout;
      logic [15:0] short_timeout;
      logic [7:0]  settle;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  command;
      logic [6:0]  node_id;
      logic [15:0] status_word;
      logic        write_ok;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [6:0]  out_node;
      logic [15:0] control_word;
      logic [1:0]  finish_code;
      logic [3:0]  drive_state;
      logic        op_enabled;
   } result_type;

endpackage

/* rtl/dpses_step.sv */
module dpses_step (
   input  dpses_pkg::state_type  cur,
   input  dpses_pkg::cfg_type    cfg,
   input  dpses_pkg::item_type   item,
   output dpses_pkg::state_type  nxt,
   output logic                  res_valid,
   output dpses_pkg::result_type res
);
   import dpses_pkg::*;

   function automatic drive_state_type decode(input logic [15:0] sw);
      drive_state_type d;
      if ((sw & 16'h004F) == 16'h0000)      d = ST_NOTREADY;
      else if ((sw & 16'h004F) == 16'h0040) d = ST_SOD;
      else if ((sw & 16'h006F) == 16'h0021) d = ST_RTSO;
      else if ((sw & 16'h006F) == 16'h0023) d = ST_SO;
      else if ((sw & 16'h006F) == 16'h0027) d = ST_OE;
      else if ((sw & 16'h006F) == 16'h0007) d = ST_QSA;
      else if ((sw & 16'h004F) == 16'h000F) d = ST_FRA;
      else if ((sw & 16'h004F) == 16'h0008) d = ST_FAULT;
      else                                  d = ST_UNKNOWN;
      return d;
   endfunction

   function automatic logic is_wait(input step_type s);
      return s inside {S_W_FAULT, S_W_SOD_RST, S_W_SOD_NR, S_W_RTSO, S_W_SO,
                       S_W_OE, S_W_SINGLE};
   endfunction

   function automatic logic is_ack(input step_type s);
      return s inside {S_RST_ACK0, S_RST_ACK1, S_RST_ACK2, S_ACK_SHUT, S_ACK_SWON,
                       S_ACK_EN, S_ACK_SINGLE};
   endfunction

   function automatic logic is_delay(input step_type s);
      return s inside {S_SETTLE, S_RST_DLY1, S_RST_DLY2};
   endfunction

   function automatic drive_state_type expected(input step_type s, input logic [2:0] c);
      drive_state_type e;
      case (s) inside
         S_W_FAULT:                e = ST_FAULT;
         S_W_SOD_RST, S_W_SOD_NR:  e = ST_SOD;
         S_W_RTSO:                 e = ST_RTSO;
         S_W_SO:                   e = ST_SO;
         S_W_OE:                   e = ST_OE;
         default: begin
            if (c == CMD_DISABLE_VOLTAGE)  e = ST_SOD;
            else if (c == CMD_SHUTDOWN)    e = ST_RTSO;
            else                           e = ST_QSA;
         end
      endcase
      return e;
   endfunction

   function automatic logic [15:0] limit(input step_type s, input cfg_type c);
      logic [15:0] l;
      if (s == S_W_FAULT || s == S_W_SOD_RST || s == S_W_SOD_NR) l = c.long_timeout;
      else                                                       l = c.short_timeout;
      return l;
   endfunction

   logic            do_delay;
   step_type        dly_s;
   logic            dly_done;
   step_type        dd_s;
   logic            do_wait;
   step_type        wait_s;
   logic            do_match;
   step_type        match_s;
   logic            do_write;
   logic [15:0]     w_cw;
   step_type        w_next;
   logic            do_fin;
   logic [1:0]      f_code;
   logic [15:0]     inc;
   drive_state_type dec_st;

   always_comb begin
      nxt      = cur;
      do_delay = 1'b0;
      dly_s    = S_SETTLE;
      dly_done = 1'b0;
      dd_s     = S_SETTLE;
      do_wait  = 1'b0;
      wait_s   = S_W_SINGLE;
      do_match = 1'b0;
      match_s  = S_W_SINGLE;
      do_write = 1'b0;
      w_cw     = CW_ZERO;
      w_next   = S_IDLE;
      do_fin   = 1'b0;
      f_code   = FIN_OK;
      inc      = (cur.elapsed < ELAPSED_MAX) ? cur.elapsed + 16'd1 : cur.elapsed;

      case (op_type'(item.op))
         OP_COMMAND: begin
            if (cur.step == S_IDLE) begin
               case (cmd_type'(item.command))
                  CMD_ENABLE: begin
                     do_delay = 1'b1;
                     dly_s    = S_SETTLE;
                  end
                  CMD_FAULT_RESET: begin
                     do_write = 1'b1;
                     w_cw     = CW_ZERO;
                     w_next   = S_RST_ACK0;
                  end
                  CMD_DISABLE_VOLTAGE: begin
                     do_write = 1'b1;
                     w_cw     = CW_ZERO;
                     w_next   = S_ACK_SINGLE;
                  end
                  CMD_SHUTDOWN: begin
                     do_write = 1'b1;
                     w_cw     = CW_SHUTDOWN;
                     w_next   = S_ACK_SINGLE;
                  end
                  CMD_QUICK_STOP: begin
                     do_write = 1'b1;
                     w_cw     = CW_QUICK_STOP;
                     w_next   = S_ACK_SINGLE;
                  end
                  default: ;
               endcase
               if (item.command <= 3'(CMD_QUICK_STOP)) begin
                  nxt.cmd  = item.command;
                  nxt.node = item.node_id;
               end
            end
         end
         OP_STATUS: begin
            nxt.status = item.status_word;
            if (is_wait(cur.step) &&
                decode(item.status_word) == expected(cur.step, cur.cmd)) begin
               do_match = 1'b1;
               match_s  = cur.step;
            end
         end
         OP_ACK: begin
            if (is_ack(cur.step)) begin
               if (!item.write_ok) begin
                  do_fin = 1'b1;
                  f_code = FIN_WRITE_FAIL;
               end else begin
                  case (cur.step)
                     S_RST_ACK0: begin do_delay = 1'b1; dly_s  = S_RST_DLY1;  end
                     S_RST_ACK1: begin do_delay = 1'b1; dly_s  = S_RST_DLY2;  end
                     S_RST_ACK2: begin do_wait  = 1'b1; wait_s = S_W_SOD_RST; end
                     S_ACK_SHUT: begin do_wait  = 1'b1; wait_s = S_W_RTSO;    end
                     S_ACK_SWON: begin do_wait  = 1'b1; wait_s = S_W_SO;      end
                     S_ACK_EN:   begin do_wait  = 1'b1; wait_s = S_W_OE;      end
                     default:    begin do_wait  = 1'b1; wait_s = S_W_SINGLE;  end
                  endcase
               end
            end
         end
         default: begin
            if (is_delay(cur.step)) begin
               nxt.elapsed = inc;
               if (inc >= {8'd0, cfg.settle}) begin
                  dly_done = 1'b1;
                  dd_s     = cur.step;
               end
            end else if (is_wait(cur.step)) begin
               nxt.elapsed = inc;
               if (inc >= limit(cur.step, cfg)) begin
                  do_fin = 1'b1;
                  f_code = FIN_TIMEOUT;
               end
            end
         end
      endcase

      dec_st = decode(nxt.status);

      if (do_delay) begin
         nxt.step    = dly_s;
         nxt.elapsed = '0;
         if (cfg.settle == 8'd0) begin
            dly_done = 1'b1;
            dd_s     = dly_s;
         end
      end

      if (dly_done) begin
         if (dd_s == S_RST_DLY1) begin
            do_write = 1'b1;
            w_cw     = CW_FAULT_RESET;
            w_next   = S_RST_ACK1;
         end else if (dd_s == S_RST_DLY2) begin
            do_write = 1'b1;
            w_cw     = CW_ZERO;
            w_next   = S_RST_ACK2;
         end else if (dec_st == ST_FAULT) begin
            do_write = 1'b1;
            w_cw     = CW_ZERO;
            w_next   = S_RST_ACK0;
         end else if (dec_st == ST_FRA) begin
            do_wait = 1'b1;
            wait_s  = S_W_FAULT;
         end else if (dec_st == ST_NOTREADY) begin
            do_wait = 1'b1;
            wait_s  = S_W_SOD_NR;
         end else begin
            do_write = 1'b1;
            w_cw     = CW_SHUTDOWN;
            w_next   = S_ACK_SHUT;
         end
      end

      if (do_wait) begin
         nxt.step    = wait_s;
         nxt.elapsed = '0;
         if (limit(wait_s, cfg) == 16'd0) begin
            do_fin = 1'b1;
            f_code = FIN_TIMEOUT;
         end else if (dec_st == expected(wait_s, nxt.cmd)) begin
            do_match = 1'b1;
            match_s  = wait_s;
         end
      end

      if (do_match) begin
         case (match_s)
            S_W_FAULT: begin
               do_write = 1'b1;
               w_cw     = CW_ZERO;
               w_next   = S_RST_ACK0;
            end
            S_W_SOD_RST: begin
               if (nxt.cmd == CMD_FAULT_RESET) begin
                  do_fin = 1'b1;
                  f_code = FIN_OK;
               end else begin
                  do_write = 1'b1;
                  w_cw     = CW_SHUTDOWN;
                  w_next   = S_ACK_SHUT;
               end
            end
            S_W_SOD_NR: begin
               do_write = 1'b1;
               w_cw     = CW_SHUTDOWN;
               w_next   = S_ACK_SHUT;
            end
            S_W_RTSO: begin
               do_write = 1'b1;
               w_cw     = CW_SWITCH_ON;
               w_next   = S_ACK_SWON;
            end
            S_W_SO: begin
               do_write = 1'b1;
               w_cw     = CW_ENABLE_OP;
               w_next   = S_ACK_EN;
            end
            default: begin
               do_fin = 1'b1;
               f_code = FIN_OK;
            end
         endcase
      end

      res_valid        = do_write || do_fin;
      res.out_node     = nxt.node;
      res.drive_state  = 4'(dec_st);
      res.op_enabled   = (dec_st == ST_OE);
      if (do_fin) begin
         nxt.step         = S_IDLE;
         nxt.elapsed      = '0;
         res.kind         = KIND_DONE;
         res.control_word = CW_ZERO;
         res.finish_code  = f_code;
      end else begin
         if (do_write) begin
            nxt.step    = w_next;
            nxt.elapsed = '0;
         end
         res.kind         = KIND_WRITE;
         res.control_word = w_cw;
         res.finish_code  = FIN_OK;
      end
   end

endmodule

/* rtl/dpses_out_buf.sv */
module dpses_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dpses_pkg::result_type push_item,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output dpses_pkg::result_type head
);
   import dpses_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

endmodule

/* rtl/drive_power_state_enable_sequencer_core.sv */
// channel   direction  ports          handshake
// req       in         req_*          req_valid / req_stall
// rsp       out        rsp_*          rsp_valid / rsp_stall
// csr       in/out     psel, paddr..  APB write on psel & penable & pwrite
//
// One item per cycle while req_stall is low: every item is decoded and
// applied to the sequencer state in the cycle it is accepted; its result,
// if any, goes into a two-entry output queue whose head drives rsp.
// req_stall is high exactly while both queue entries are occupied.
// Synchronous reset clears the sequencer to idle and the registers to
// their defaults (1000, 500, 5).
module drive_power_state_enable_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_command,
   input  logic [6:0]  req_node_id,
   input  logic [15:0] req_status_word,
   input  logic        req_write_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [6:0]  rsp_out_node,
   output logic [15:0] rsp_control_word,
   output logic [1:0]  rsp_finish_code,
   output logic [3:0]  rsp_drive_state,
   output logic        rsp_op_enabled,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dpses_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_ff;
   state_type  state_in;
   item_type   item;
   logic       accept;
   logic       res_valid;
   result_type res;
   result_type head;
   logic       buf_full;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_LONG_TIMEOUT:  cfg_in.long_timeout  = pwdata[15:0];
            REG_SHORT_TIMEOUT: cfg_in.short_timeout = pwdata[15:0];
            REG_SETTLE:        cfg_in.settle        = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_LONG_TIMEOUT:  prdata = {16'd0, cfg_ff.long_timeout};
         REG_SHORT_TIMEOUT: prdata = {16'd0, cfg_ff.short_timeout};
         REG_SETTLE:        prdata = {24'd0, cfg_ff.settle};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_timeout  <= 16'd1000;
         cfg_ff.short_timeout <= 16'd500;
         cfg_ff.settle        <= 8'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign item.op          = req_op;
   assign item.command     = req_command;
   assign item.node_id     = req_node_id;
   assign item.status_word = req_status_word;
   assign item.write_ok    = req_write_ok;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   dpses_step u_step (
      .cur       (state_ff),
      .cfg       (cfg_ff),
      .item      (item),
      .nxt       (state_in),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.status  <= 16'd0;
         state_ff.step    <= S_IDLE;
         state_ff.elapsed <= 16'd0;
         state_ff.node    <= 7'd0;
         state_ff.cmd     <= 3'd0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   dpses_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_item (res),
      .pop       (rsp_valid && !rsp_stall),
      .full      (buf_full),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_out_node     = head.out_node;
   assign rsp_control_word = head.control_word;
   assign rsp_finish_code  = head.finish_code;
   assign rsp_drive_state  = head.drive_state;
   assign rsp_op_enabled   = head.op_enabled;

endmodule

/* rtl/dpses_checker.sv */
module dpses_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [6:0]  rsp_out_node,
   input logic [15:0] rsp_control_word,
   input logic [1:0]  rsp_finish_code,
   input logic [3:0]  rsp_drive_state,
   input logic        rsp_op_enabled
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_control_word) && $stable(rsp_kind)
                                 && $stable(rsp_out_node) && $stable(rsp_finish_code)
                                 && $stable(rsp_drive_state) && $stable(rsp_op_enabled))
      else $error("rsp item changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty result queue");

   a_pop_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !(req_valid && !req_stall) |=> !req_stall)
      else $error("req still stalled after a result left");

endmodule

bind drive_power_state_enable_sequencer_core dpses_checker u_checker (.*);
